FILE: rtl/core/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths, item types and helpers for the segment/sphere test pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int CW    = 32;          // coordinate width
  localparam int DW    = CW + 1;      // difference width
  localparam int PW    = 2 * DW;      // product width
  localparam int NW    = PW + 2;      // sum of three products
  localparam int MW    = CW;          // magnitude of a difference / quotient
  localparam int RW    = NW;          // divider remainder width
  localparam int RADW  = CW - 1;      // radius width
  localparam int RRW   = 2 * RADW;    // squared radius width
  localparam int NREG  = 6;
  localparam int AW    = $clog2(NREG * 4);

  localparam int DOT_LAT = 3;
  localparam int DIV_LAT = MW + 2;
  localparam int HIT_LAT = 5;
  localparam int LATENCY = DOT_LAT + DIV_LAT + HIT_LAT;

  // register indexes
  localparam logic [AW-3:0] REG_START_X = (AW-2)'(0);
  localparam logic [AW-3:0] REG_START_Y = (AW-2)'(1);
  localparam logic [AW-3:0] REG_START_Z = (AW-2)'(2);
  localparam logic [AW-3:0] REG_END_X   = (AW-2)'(3);
  localparam logic [AW-3:0] REG_END_Y   = (AW-2)'(4);
  localparam logic [AW-3:0] REG_END_Z   = (AW-2)'(5);

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t [2:0]         vec_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef diff_t [2:0]          dvec_t;

  typedef struct packed {
    coord_t          center_x;
    coord_t          center_y;
    coord_t          center_z;
    logic [RADW-1:0] radius;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    coord_t near_x;
    coord_t near_y;
    coord_t near_z;
  } out_item_t;

  typedef struct packed {
    vec_t s;
    vec_t e;
  } seg_t;

  typedef enum logic [1:0] {
    SEL_START,
    SEL_END,
    SEL_DIV
  } sel_t;

  typedef struct packed {
    logic            valid;
    vec_t            c;
    logic [RRW-1:0]  rr;
    dvec_t           d;
    logic [NW-1:0]   num;
    logic [NW-1:0]   den;
  } dot_t;

  typedef struct packed {
    logic                 valid;
    vec_t                 c;
    logic [RRW-1:0]       rr;
    sel_t                 sel;
    logic [2:0]           dneg;
    logic [2:0][MW-1:0]   q;
  } div_t;

  function automatic diff_t sx(coord_t a);
    return {a[CW-1], a};
  endfunction

endpackage

FILE: rtl/core/segment_sphere_intersect.sv
// ----------------------------------------------------------------------------
// segment_sphere_intersect
// Closest point on a configured segment to a sphere centre, and a hit flag.
// ----------------------------------------------------------------------------
// Usage:
//   Program the segment start and end through the APB port (six registers at
//   byte addresses 0x00..0x14: start x/y/z, end x/y/z) while no item is in
//   flight. Present a sphere on item and pulse start; busy stays low, so an
//   item is taken every cycle start is high - one item per clock.
//   Each item gives one result on result, marked by a one-cycle done strobe,
//   after 3 stages of differences, products and dot sums, 34 stages of the
//   per-axis long division (one quotient bit per stage for 32 bits, a
//   classify stage and a rounding stage), and 5 stages of closest point,
//   distance and radius compare.
//   The division pipeline is the longest part; throughput is one item per cycle.
//   The receiver cannot stall, so results are never held back.
//   Reset clears all valid bits in the pipeline and the six registers to 0.
// ----------------------------------------------------------------------------
module segment_sphere_intersect (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ssi_pkg::in_item_t     item,
  output logic                  done,
  output ssi_pkg::out_item_t    result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ssi_pkg::AW-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ssi_pkg::*;

  coord_t        cfg [NREG];
  logic [AW-3:0] ridx;
  seg_t          seg;
  dot_t          dot;
  div_t          dv;

  // the pipeline never holds off an item
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign ridx   = paddr[AW-1:2];

  // register file; writes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) begin
        cfg[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready && ridx < (AW-2)'(NREG)) begin
      cfg[ridx] <= pwdata;
    end
  end

  assign prdata = (ridx < (AW-2)'(NREG)) ? cfg[ridx] : '0;

  assign seg.s[0] = cfg[REG_START_X];
  assign seg.s[1] = cfg[REG_START_Y];
  assign seg.s[2] = cfg[REG_START_Z];
  assign seg.e[0] = cfg[REG_END_X];
  assign seg.e[1] = cfg[REG_END_Y];
  assign seg.e[2] = cfg[REG_END_Z];

  // dot products feed the divider, which feeds the distance check
  ssi_dot u_dot (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .in_item  (item),
    .seg      (seg),
    .dot      (dot)
  );

  ssi_div u_div (
    .clk (clk),
    .rst (rst),
    .dot (dot),
    .dv  (dv)
  );

  ssi_hit u_hit (
    .clk       (clk),
    .rst       (rst),
    .dv        (dv),
    .seg       (seg),
    .res_valid (done),
    .res       (result)
  );

  // every result comes from an item taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  // a zero-length segment yields its start point
  a_degenerate: assert property (@(posedge clk) disable iff (rst)
    (done && cfg[REG_START_X] == cfg[REG_END_X] && cfg[REG_START_Y] == cfg[REG_END_Y]
     && cfg[REG_START_Z] == cfg[REG_END_Z])
    |-> (result.near_x == cfg[REG_START_X] && result.near_y == cfg[REG_START_Y]
         && result.near_z == cfg[REG_START_Z]))
    else $error("degenerate segment did not give the start point");

endmodule

FILE: rtl/core/ssi_dot.sv
// ----------------------------------------------------------------------------
// ssi_dot
// Three-stage front end: differences, products, dot-product sums.
// ----------------------------------------------------------------------------
module ssi_dot (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ssi_pkg::in_item_t in_item,
  input  ssi_pkg::seg_t    seg,
  output ssi_pkg::dot_t    dot
);
  import ssi_pkg::*;

  logic            v1, v2;
  vec_t            c1, c2;
  logic [RADW-1:0] rad1;
  logic [RRW-1:0]  rr2;
  dvec_t           d1, w1, d2;
  logic signed [PW-1:0] pdw [3];
  logic signed [PW-1:0] pdd [3];
  vec_t            cin;

  assign cin[0] = in_item.center_x;
  assign cin[1] = in_item.center_y;
  assign cin[2] = in_item.center_z;

  always_ff @(posedge clk) begin
    v1   <= rst ? 1'b0 : in_valid;
    c1   <= cin;
    rad1 <= in_item.radius;
    for (int i = 0; i < 3; i++) begin
      d1[i] <= sx(seg.e[i]) - sx(seg.s[i]);
      w1[i] <= sx(cin[i]) - sx(seg.s[i]);
    end
  end

  always_ff @(posedge clk) begin
    v2  <= rst ? 1'b0 : v1;
    c2  <= c1;
    d2  <= d1;
    rr2 <= RRW'(rad1) * RRW'(rad1);
    for (int i = 0; i < 3; i++) begin
      pdw[i] <= d1[i] * w1[i];
      pdd[i] <= d1[i] * d1[i];
    end
  end

  always_ff @(posedge clk) begin
    dot.valid <= rst ? 1'b0 : v2;
    dot.c     <= c2;
    dot.rr    <= rr2;
    dot.d     <= d2;
    dot.num   <= {{2{pdw[0][PW-1]}}, pdw[0]} + {{2{pdw[1][PW-1]}}, pdw[1]}
               + {{2{pdw[2][PW-1]}}, pdw[2]};
    dot.den   <= {2'b00, pdd[0]} + {2'b00, pdd[1]} + {2'b00, pdd[2]};
  end

endmodule

FILE: rtl/core/ssi_div.sv
// ----------------------------------------------------------------------------
// ssi_div
// Classify the segment parameter, then a pipelined long division per axis:
// one quotient bit per stage, then a rounding stage.
// ----------------------------------------------------------------------------
module ssi_div (
  input  logic          clk,
  input  logic          rst,
  input  ssi_pkg::dot_t dot,
  output ssi_pkg::div_t dv
);
  import ssi_pkg::*;

  typedef struct packed {
    logic                valid;
    vec_t                c;
    logic [RRW-1:0]      rr;
    sel_t                sel;
    logic [2:0]          dneg;
    logic [2:0][MW-1:0]  m;
    logic [2:0][RW-1:0]  r;
    logic [2:0][MW-1:0]  q;
    logic [RW-1:0]       num;
    logic [RW-1:0]       den;
  } dstage_t;

  dstage_t st [MW+1];
  dstage_t ent;

  function automatic dstage_t div_step(dstage_t a, logic clr);
    dstage_t       b;
    logic [RW-1:0] t;
    logic [RW-1:0] den2;
    logic [1:0]    k;
    b       = a;
    b.valid = a.valid && !clr;
    den2    = {a.den[RW-2:0], 1'b0};
    for (int i = 0; i < 3; i++) begin
      t = {a.r[i][RW-2:0], 1'b0} + (a.m[i][MW-1] ? a.num : '0);
      if (t >= den2) begin
        b.r[i] = t - den2;
        k      = 2'd2;
      end else if (t >= a.den) begin
        b.r[i] = t - a.den;
        k      = 2'd1;
      end else begin
        b.r[i] = t;
        k      = 2'd0;
      end
      b.q[i] = {a.q[i][MW-2:0], 1'b0} + MW'(k);
      b.m[i] = {a.m[i][MW-2:0], 1'b0};
    end
    return b;
  endfunction

  // entry: choose start, end or interior point
  always_comb begin
    ent.valid = dot.valid && !rst;
    ent.c     = dot.c;
    ent.rr    = dot.rr;
    ent.num   = dot.num;
    ent.den   = dot.den;
    ent.r     = '0;
    ent.q     = '0;
    if (dot.den == '0 || dot.num[NW-1] || dot.num == '0) begin
      ent.sel = SEL_START;
    end else if (dot.num >= dot.den) begin
      ent.sel = SEL_END;
    end else begin
      ent.sel = SEL_DIV;
    end
    for (int i = 0; i < 3; i++) begin
      ent.dneg[i] = dot.d[i][DW-1];
      ent.m[i]    = dot.d[i][DW-1] ? MW'(-dot.d[i]) : MW'(dot.d[i]);
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= ent;
  end

  for (genvar k = 0; k < MW; k++) begin : g_step
    always_ff @(posedge clk) begin
      st[k+1] <= div_step(st[k], rst);
    end
  end

  // round half up on the remainder
  always_ff @(posedge clk) begin
    dv.valid <= rst ? 1'b0 : st[MW].valid;
    dv.c     <= st[MW].c;
    dv.rr    <= st[MW].rr;
    dv.sel   <= st[MW].sel;
    dv.dneg  <= st[MW].dneg;
    for (int i = 0; i < 3; i++) begin
      dv.q[i] <= st[MW].q[i]
               + MW'({st[MW].r[i], 1'b0} >= {1'b0, st[MW].den});
    end
  end

endmodule

FILE: rtl/core/ssi_hit.sv
// ----------------------------------------------------------------------------
// ssi_hit
// Closest point, squared distance to the centre and the radius compare.
// ----------------------------------------------------------------------------
module ssi_hit (
  input  logic               clk,
  input  logic               rst,
  input  ssi_pkg::div_t      dv,
  input  ssi_pkg::seg_t      seg,
  output logic               res_valid,
  output ssi_pkg::out_item_t res
);
  import ssi_pkg::*;

  logic vn, vg, vm, vs;
  vec_t near_n, near_g, near_m, near_s, c_n;
  logic [RRW-1:0] rr_n, rr_g, rr_m, rr_s;
  dvec_t g;
  logic signed [PW-1:0] gg [3];
  logic [NW-1:0] dist_sq;

  always_ff @(posedge clk) begin
    vn   <= rst ? 1'b0 : dv.valid;
    c_n  <= dv.c;
    rr_n <= dv.rr;
    for (int i = 0; i < 3; i++) begin
      unique case (dv.sel)
        SEL_START: near_n[i] <= seg.s[i];
        SEL_END:   near_n[i] <= seg.e[i];
        SEL_DIV:   near_n[i] <= dv.dneg[i]
                              ? CW'(sx(seg.s[i]) - DW'(dv.q[i]))
                              : CW'(sx(seg.s[i]) + DW'(dv.q[i]));
        default:   near_n[i] <= seg.s[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    vg     <= rst ? 1'b0 : vn;
    near_g <= near_n;
    rr_g   <= rr_n;
    for (int i = 0; i < 3; i++) begin
      g[i] <= sx(c_n[i]) - sx(near_n[i]);
    end
  end

  always_ff @(posedge clk) begin
    vm     <= rst ? 1'b0 : vg;
    near_m <= near_g;
    rr_m   <= rr_g;
    for (int i = 0; i < 3; i++) begin
      gg[i] <= g[i] * g[i];
    end
  end

  always_ff @(posedge clk) begin
    vs      <= rst ? 1'b0 : vm;
    near_s  <= near_m;
    rr_s    <= rr_m;
    dist_sq <= {2'b00, gg[0]} + {2'b00, gg[1]} + {2'b00, gg[2]};
  end

  always_ff @(posedge clk) begin
    res_valid  <= rst ? 1'b0 : vs;
    res.hit    <= dist_sq <= NW'(rr_s);
    res.near_x <= near_s[0];
    res.near_y <= near_s[1];
    res.near_z <= near_s[2];
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams sphere queries into segment_sphere_intersect under several segment
// settings and checks every closest point and hit flag against a local model.
// ----------------------------------------------------------------------------

// Holds the segment copy and the queue of predicted answers.
class sphere_answer_board;
  logic signed [31:0] seg_start [3];
  logic signed [31:0] seg_end [3];
  ssi_pkg::out_item_t answers [$];
  int errors;

  function new();
    for (int i = 0; i < 3; i++) begin
      seg_start[i] = '0;
      seg_end[i] = '0;
    end
    errors = 0;
  endfunction

  // Round |m| * num / den to nearest, halves away from zero.
  function automatic longint scaled_share(longint m, logic [127:0] num, logic [127:0] den);
    logic [191:0] prod;
    logic [191:0] q;
    logic [191:0] r;
    prod = 192'(m) * 192'(num);
    q = prod / 192'(den);
    r = prod - q * 192'(den);
    if ((r << 1) >= 192'(den)) q = q + 1;
    return longint'(q[63:0]);
  endfunction

  function void note_query(ssi_pkg::in_item_t it);
    longint s [3];
    longint e [3];
    longint c [3];
    longint d [3];
    longint nr [3];
    longint g;
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic [127:0] dist_sq;
    logic [127:0] rr;
    longint q;
    ssi_pkg::out_item_t a;
    c[0] = longint'(it.center_x);
    c[1] = longint'(it.center_y);
    c[2] = longint'(it.center_z);
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'(seg_start[i]);
      e[i] = longint'(seg_end[i]);
      d[i] = e[i] - s[i];
      num += 128'(signed'(d[i])) * 128'(signed'(c[i] - s[i]));
      den += 128'(signed'(d[i])) * 128'(signed'(d[i]));
    end
    for (int i = 0; i < 3; i++) begin
      if (den == 0 || num <= 0) nr[i] = s[i];
      else if (num >= den) nr[i] = e[i];
      else begin
        q = scaled_share(d[i] < 0 ? -d[i] : d[i], num, den);
        nr[i] = s[i] + (d[i] < 0 ? -q : q);
      end
    end
    dist_sq = 0;
    for (int i = 0; i < 3; i++) begin
      g = c[i] - nr[i];
      dist_sq += 128'(signed'(g)) * 128'(signed'(g));
    end
    rr = 128'(it.radius) * 128'(it.radius);
    a.hit = (dist_sq <= rr);
    a.near_x = nr[0][31:0];
    a.near_y = nr[1][31:0];
    a.near_z = nr[2][31:0];
    answers.push_back(a);
  endfunction

  function void check_answer(ssi_pkg::out_item_t got);
    ssi_pkg::out_item_t exp;
    if (answers.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = answers.pop_front();
    if (got.hit !== exp.hit) begin
      $display("%0t: hit exp %0b got %0b", $time, exp.hit, got.hit);
      errors++;
    end
    if (got.near_x !== exp.near_x) begin
      $display("%0t: near_x exp %h got %h", $time, exp.near_x, got.near_x);
      errors++;
    end
    if (got.near_y !== exp.near_y) begin
      $display("%0t: near_y exp %h got %h", $time, exp.near_y, got.near_y);
      errors++;
    end
    if (got.near_z !== exp.near_z) begin
      $display("%0t: near_z exp %h got %h", $time, exp.near_z, got.near_z);
      errors++;
    end
  endfunction
endclass

module testbench;
  import ssi_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t item = '0;
  logic done;
  out_item_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sphere_answer_board board = new();
  int quiet_cycles = 0;
  bit calm_stretch = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  segment_sphere_intersect dut (.*);

  // Check results and feed the watchdog at every rising edge.
  always @(posedge clk) begin
    if (!rst && done) board.check_answer(result);
    if ((start && !busy) || done || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("FAIL segment_sphere_intersect");
      $finish;
    end
  end

  // Write one segment register over APB; setup then access.
  task automatic write_segment(logic [AW-3:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < 3) board.seg_start[idx] = val;
    else board.seg_end[idx - 3] = val;
  endtask

  // Drain the pipeline, then give it its full latency before touching the segment.
  task automatic wait_idle();
    while (board.answers.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic load_segment(logic [31:0] sx0, logic [31:0] sy0, logic [31:0] sz0,
                              logic [31:0] ex0, logic [31:0] ey0, logic [31:0] ez0);
    wait_idle();
    write_segment(REG_START_X, sx0);
    write_segment(REG_START_Y, sy0);
    write_segment(REG_START_Z, sz0);
    write_segment(REG_END_X, ex0);
    write_segment(REG_END_Y, ey0);
    write_segment(REG_END_Z, ez0);
  endtask

  // Offer one query; hold start until it is taken, with random idle gaps first.
  task automatic send_query(in_item_t q);
    while (!calm_stretch && $urandom_range(99) < 26) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_query(q);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord(int scale);
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'(signed'($urandom_range(2 * scale)) - scale);
    endcase
  endfunction

  function automatic in_item_t random_sphere(int scale);
    in_item_t q;
    q.center_x = pick_coord(scale);
    q.center_y = pick_coord(scale);
    q.center_z = pick_coord(scale);
    case ($urandom_range(3))
      0: q.radius = 31'($urandom);
      1: q.radius = '1;
      default: q.radius = 31'($urandom_range(scale));
    endcase
    return q;
  endfunction

  task automatic random_phase(int n, int scale);
    for (int i = 0; i < n; i++) begin
      calm_stretch = (i >= n / 3 && i < n / 3 + 60);
      send_query(random_sphere(scale));
    end
    calm_stretch = 0;
    start <= 1'b0;
  endtask

  initial begin
    in_item_t q;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero-length segment at reset: near is always the start point.
    q = '{32'sh0001_0000, -32'sh0002_0000, 32'sh0, 31'h1_0000};
    send_query(q);
    start <= 1'b0;
    load_segment(32'h0, 32'h0, 32'h0, 32'h000a_0000, 32'h0, 32'h0);
    // Before the start, beyond the end, inside, one step past the start, on the end, extremes.
    q = '{-32'sh0005_0000, 32'sh0001_0000, 32'sh0, 31'h1_0000};
    send_query(q);
    q = '{32'sh0014_0000, 32'sh0, 32'sh0, 31'h0};
    send_query(q);
    q = '{32'sh0003_8000, 32'sh0002_0000, 32'sh0, 31'h2_0000};
    send_query(q);
    q = '{32'sh0000_0001, 32'sh0, 32'sh0, 31'h0};
    send_query(q);
    q = '{32'sh000a_0000, 32'sh0, 32'sh0, 31'h0};
    send_query(q);
    q = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff};
    send_query(q);
    q = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff};
    send_query(q);
    start <= 1'b0;
    // Extreme diagonal segment with a negative direction.
    load_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    q = '{32'h0, 32'h0, 32'h0, 31'h0};
    send_query(q);
    q = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_1234, 31'h7fff_ffff};
    send_query(q);
    q = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0};
    send_query(q);
    q = '{32'h0000_0003, 32'hffff_fff9, 32'h0000_0005, 31'h1};
    send_query(q);
    start <= 1'b0;

    random_phase(400, 32'h0100_0000);
    // Sender holds off until every answer is back.
    wait_idle();
    random_phase(150, 32'h0100_0000);
    load_segment(32'hfff0_0000, 32'h0003_0000, 32'h0, 32'h0010_0000, 32'hfffd_0000, 32'h0);
    random_phase(450, 32'h0020_0000);
    load_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(350, 32'h7fff_ffff);
    load_segment(32'h0001_2345, 32'h0001_2345, 32'h0001_2345,
                 32'h0001_2345, 32'h0001_2345, 32'h0001_2345);
    random_phase(100, 32'h0004_0000);
    load_segment(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1);
    random_phase(300, 32'h7fff_ffff);

    wait_idle();
    if (board.errors == 0 && board.answers.size() == 0) begin
      $display("PASS segment_sphere_intersect");
    end else begin
      $display("FAIL segment_sphere_intersect");
    end
    $finish;
  end
endmodule
